// ===== rtl/core/bdmc_pkg.sv =====
// package: shared constants, types and register indexes for the broadcast delivery estimator
`default_nettype none
package bdmc_pkg;

  localparam int MAX_DEST     = 4;
  localparam int COUNT_WIDTH  = 32;
  localparam int PROB_REGS    = 4;
  localparam int PROB_W       = 17;
  localparam int CNT_W        = 16;
  localparam int TARGET_W     = 16;
  localparam int MASK_W       = 4;
  localparam int NDEST_W      = 3;
  localparam int RAND_W       = 7;
  localparam int TRANS_W      = 32;
  localparam int HIT_W        = 5;
  localparam int CUM_W        = 21;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;
  localparam int Q_DEPTH      = 2;

  localparam int TABLE_DEPTH  = 1 << MAX_DEST;
  localparam int IDX_W        = MAX_DEST;
  localparam int N_W          = $clog2(MAX_DEST + 1);
  localparam int SH_W         = (MAX_DEST > 1) ? $clog2(MAX_DEST) : 1;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_FILL_W     = $clog2(Q_DEPTH + 1);
  localparam int LHS_W        = RAND_W + 16;
  localparam int RHS_W        = CUM_W + 7;

  localparam logic [PROB_W-1:0]      ONE_Q16   = PROB_W'(65536);
  localparam logic [HIT_W-1:0]       NO_HIT    = HIT_W'(16);
  localparam logic [RHS_W-1:0]       HUNDRED   = RHS_W'(100);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PROB0   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROB1   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PROB2   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PROB3   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LINK    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_NDEST   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = CFG_IDX_W'(6);

  typedef struct packed {
    logic              kind;
    logic [RAND_W-1:0] random_hundredths;
  } in_word_t;

  typedef struct packed {
    logic [TRANS_W-1:0] transmissions;
    logic               done_res;
    logic [HIT_W-1:0]   hit_pattern;
  } out_word_t;

  typedef struct packed {
    logic [PROB_REGS-1:0][PROB_W-1:0] prob;
    logic [MASK_W-1:0]                link_mask;
    logic [NDEST_W-1:0]               dest_count;
    logic [TARGET_W-1:0]              trials_target;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_word_t item;
  } queue_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_CMP,
    ST_UPD
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/bdmc_front.sv =====
// front end: configuration registers and the command queue feeding the back end
`default_nettype none
module bdmc_front
  import bdmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg,
  output queue_head_t                head,
  input  wire logic                  pop
);

  cfg_t                cfg_r;
  in_word_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_FILL_W-1:0] fill_r;
  logic                push;
  logic                do_pop;

  assign cfg_ready = 1'b1;
  assign busy      = (fill_r == Q_FILL_W'(Q_DEPTH));
  assign push      = start && !busy;
  assign do_pop    = pop && (fill_r != '0);
  assign cfg       = cfg_r;
  assign head.valid = (fill_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prob[0]        <= PROB_W'(39322);
      cfg_r.prob[1]        <= PROB_W'(26214);
      cfg_r.prob[2]        <= '0;
      cfg_r.prob[3]        <= '0;
      cfg_r.link_mask      <= MASK_W'(3);
      cfg_r.dest_count     <= NDEST_W'(2);
      cfg_r.trials_target  <= TARGET_W'(10000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROB0:  cfg_r.prob[0]       <= cfg_data;
        REG_PROB1:  cfg_r.prob[1]       <= cfg_data;
        REG_PROB2:  cfg_r.prob[2]       <= cfg_data;
        REG_PROB3:  cfg_r.prob[3]       <= cfg_data;
        REG_LINK:   cfg_r.link_mask     <= cfg_data[MASK_W-1:0];
        REG_NDEST:  cfg_r.dest_count    <= cfg_data[NDEST_W-1:0];
        REG_TARGET: cfg_r.trials_target <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !do_pop) begin
        fill_r <= fill_r + Q_FILL_W'(1);
      end else if (!push && do_pop) begin
        fill_r <= fill_r - Q_FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_word;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bdmc_back.sv =====
// back end: table build sequencer, draw compare and counter update
`default_nettype none
module bdmc_back
  import bdmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire queue_head_t head,
  output logic             pop,
  output logic             out_valid,
  output out_word_t        out_word
);

  back_state_t              state_r, state_nxt;
  logic [N_W-1:0]           n_r, n_nxt;
  logic [IDX_W-1:0]         i_r, i_nxt;
  logic [N_W-1:0]           j_r, j_nxt;
  logic [PROB_W-1:0]        val_r, val_nxt;
  logic [CUM_W-1:0]         sum_r, sum_nxt;
  logic [RAND_W-1:0]        rnd_r, rnd_nxt;
  logic [HIT_W-1:0]         hit_r, hit_nxt;
  logic [CNT_W-1:0]         cnt_r [MAX_DEST];
  logic [CNT_W-1:0]         cnt_nxt [MAX_DEST];
  logic [COUNT_WIDTH-1:0]   count_r, count_nxt;
  logic                     done_r, done_nxt;
  logic [CUM_W-1:0]         table_r [TABLE_DEPTH];
  logic                     tbl_we;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  logic [N_W-1:0]           n_cfg;
  logic [IDX_W:0]           tsize;
  logic [IDX_W:0]           last_idx;
  logic                     entry_end;
  logic [N_W-1:0]           bsh;
  logic [PROB_W-1:0]        p_raw;
  logic [PROB_W-1:0]        p_clamp;
  logic [PROB_W-1:0]        factor;
  logic [2*PROB_W-1:0]      prod;
  logic [CUM_W-1:0]         sum_step;
  logic [LHS_W-1:0]         lhs;
  logic [TABLE_DEPTH-1:0]   below;
  logic [HIT_W-1:0]         hit_sel;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign pop       = (state_r == ST_IDLE) && head.valid;

  assign n_cfg     = (cfg.dest_count > NDEST_W'(MAX_DEST)) ? N_W'(MAX_DEST)
                                                           : N_W'(cfg.dest_count);
  assign tsize     = (IDX_W+1)'(1) << n_r;
  assign last_idx  = tsize - (IDX_W+1)'(1);
  assign entry_end = (j_r == n_r);

  // factor for destination j of pattern i during table build
  assign bsh      = n_r - N_W'(1) - j_r;
  assign p_raw    = cfg.prob[j_r[SH_W-1:0]];
  assign p_clamp  = (p_raw > ONE_Q16) ? ONE_Q16 : p_raw;
  always_comb begin
    if (!cfg.link_mask[j_r[SH_W-1:0]]) begin
      factor = ONE_Q16;
    end else if (i_r[bsh[SH_W-1:0]]) begin
      factor = p_clamp;
    end else begin
      factor = ONE_Q16 - p_clamp;
    end
  end
  assign prod     = (2*PROB_W)'(val_r) * (2*PROB_W)'(factor);
  assign sum_step = sum_r + CUM_W'(val_r);

  // draw compare over all entries
  assign lhs = {rnd_r, 16'b0};
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      below[k] = ((IDX_W+1)'(k) < tsize) &&
                 ((RHS_W'(lhs)) < (RHS_W'(table_r[k]) * HUNDRED));
    end
  end
  always_comb begin
    hit_sel = NO_HIT;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (below[k]) begin
        hit_sel = HIT_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.item.kind == KIND_START) begin
            state_nxt = ST_BUILD;
          end else if (!done_r) begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_BUILD: begin
        if (entry_end && ({1'b0, i_r} == last_idx)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [N_W-1:0] sh;
    logic           all_zero;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    val_nxt       = val_r;
    sum_nxt       = sum_r;
    rnd_nxt       = rnd_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    tbl_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    sh            = '0;
    all_zero      = 1'b1;
    for (int j = 0; j < MAX_DEST; j++) begin
      cnt_nxt[j] = cnt_r[j];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.item.kind == KIND_START) begin
            n_nxt     = n_cfg;
            i_nxt     = '0;
            j_nxt     = '0;
            val_nxt   = ONE_Q16;
            sum_nxt   = '0;
            count_nxt = '0;
            done_nxt  = (n_cfg == '0) || (cfg.trials_target == '0);
            for (int j = 0; j < MAX_DEST; j++) begin
              cnt_nxt[j] = (N_W'(j) < n_cfg) ? cfg.trials_target : '0;
            end
          end else if (done_r) begin
            out_valid_nxt              = 1'b1;
            out_word_nxt.transmissions = TRANS_W'(count_r);
            out_word_nxt.done_res      = done_r;
            out_word_nxt.hit_pattern   = NO_HIT;
          end else begin
            rnd_nxt = head.item.random_hundredths;
          end
        end
      end
      ST_BUILD: begin
        if (entry_end) begin
          tbl_we  = 1'b1;
          sum_nxt = sum_step;
          i_nxt   = i_r + IDX_W'(1);
          j_nxt   = '0;
          val_nxt = ONE_Q16;
          if ({1'b0, i_r} == last_idx) begin
            out_valid_nxt              = 1'b1;
            out_word_nxt.transmissions = TRANS_W'(count_r);
            out_word_nxt.done_res      = done_r;
            out_word_nxt.hit_pattern   = NO_HIT;
          end
        end else begin
          val_nxt = prod[16 +: PROB_W];
          j_nxt   = j_r + N_W'(1);
        end
      end
      ST_CMP: begin
        hit_nxt = hit_sel;
      end
      ST_UPD: begin
        for (int j = 0; j < MAX_DEST; j++) begin
          if (N_W'(j) < n_r) begin
            sh = n_r - N_W'(1) - N_W'(j);
            if ((hit_r != NO_HIT) && hit_r[sh[SH_W-1:0]] && (cnt_r[j] != '0)) begin
              cnt_nxt[j] = cnt_r[j] - CNT_W'(1);
            end
          end
          if (cnt_nxt[j] != '0) begin
            all_zero = 1'b0;
          end
        end
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_WIDTH'(1);
        end
        done_nxt                   = all_zero;
        out_valid_nxt              = 1'b1;
        out_word_nxt.transmissions = TRANS_W'(count_nxt);
        out_word_nxt.done_res      = all_zero;
        out_word_nxt.hit_pattern   = hit_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      count_r     <= '0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_DEST; j++) begin
        cnt_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < MAX_DEST; j++) begin
        cnt_r[j] <= cnt_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    val_r      <= val_nxt;
    sum_r      <= sum_nxt;
    rnd_r      <= rnd_nxt;
    hit_r      <= hit_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_r[i_r] <= sum_step;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/broadcast_delivery_monte_carlo.sv =====
// top level: broadcast delivery estimator, front queue plus back-end sequencer
//
// Commands enter on start/in_word whenever busy is low; a two-word queue sits in
// front of the executing back end, and busy is high only while that queue is full.
// Every accepted word gives one result on out_word, marked by a one-cycle
// out_valid strobe that the receiver must take (no back pressure). A start word
// builds the cumulative table with one shared 17x17 multiplier, one destination
// factor per cycle over the 2^N entries for N destinations in use; the result is
// registered as the last entry is written. A draw compares all entries in use
// at once in ST_CMP and updates the counters in the next, ST_UPD, which registers
// the result. A draw that arrives after done is answered straight from ST_IDLE.
// Configuration is taken at any time on cfg_valid (cfg_ready is always high) and
// must only change while no command is in flight.
`default_nettype none
module broadcast_delivery_monte_carlo
  import bdmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  output logic                       out_valid,
  output out_word_t                  out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  bdmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop)
  );

  bdmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bdmc_checker.sv =====
// checker: port-level properties of the broadcast delivery estimator, bound to the top
`default_nettype none
module bdmc_checker
  import bdmc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_word_t out_word
);

  // no result strobe right out of reset
  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // queue is empty after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy right after reset");

  // busy only rises after an accepted word
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

  // pattern index never beyond the no-hit code
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.hit_pattern <= NO_HIT))
    else $error("hit pattern out of range");

  // a hit always counts a transmission
  a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.hit_pattern != NO_HIT)) |-> (out_word.transmissions != '0))
    else $error("hit reported with zero transmissions");

endmodule

bind broadcast_delivery_monte_carlo bdmc_checker u_bdmc_checker (.*);
`default_nettype wire
